// ===== design/adnd_pkg.sv =====
// Shared types and constants for the adaptive delta nibble decoder.
package adnd_pkg;

  localparam int STEP_ENTRIES_DEF = 64;
  localparam int ADDR_W_MAX       = 8;
  localparam int CODE_W           = 4;
  localparam int IDX_W            = 6;
  localparam int STEP_W           = 16;
  localparam int ADJ_W            = 7;
  localparam int SAMPLE_W         = 32;
  localparam int ADJ_ENTRIES      = 16;

  typedef enum logic [1:0] {
    MODE_DECODE    = 2'd0,
    MODE_LOAD_STEP = 2'd1,
    MODE_LOAD_ADJ  = 2'd2,
    MODE_INIT      = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [CODE_W-1:0]   code;
    logic [IDX_W-1:0]    addr;
    logic [STEP_W-1:0]   value;
  } stage_t;

endpackage

// ===== design/adnd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module adnd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/adaptive_delta_nibble_decoder_core.sv =====
// Adaptive delta nibble decoder: IMA-style 4-bit code decoder with loadable tables.
//
// One item is taken every clock cycle while the result side does not stall,
// and each item gives exactly one result via the decoder stage. Items are
// decodes, step-table loads, adjust-table loads and channel inits, selected by
// mode. The step table (STEP_ENTRIES x 16) and adjust table (16 x 7, signed)
// live in RAMs with registered read data; both are undefined after
// reset and must be loaded before any decode reads them. Every item issues
// its table reads in its transfer cycle. The step read address is the step
// index left by the item one stage ahead, taken straight from that stage's
// adjust-and-clamp logic, and this RAM read is what sets the pace.
// Table writes also happen at transfer, in item order, so a load followed by
// a decode in the next cycle sees the new entry. The result channel shows
// the committed predictor and step index directly; a stalled result holds
// the decoder stage, and a held stage raises the item stall. The item stall
// is also high during reset. Load items report the unchanged state.
module adaptive_delta_nibble_decoder_core #(
  parameter int STEP_ENTRIES = adnd_pkg::STEP_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  adnd_pkg::mode_t                       mode,
  input  logic [adnd_pkg::CODE_W-1:0]           code,
  input  logic [adnd_pkg::IDX_W-1:0]            entry_addr,
  input  logic [adnd_pkg::STEP_W-1:0]           entry_value,
  input  logic signed [adnd_pkg::ADJ_W-1:0]     adjust_value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [adnd_pkg::SAMPLE_W-1:0]  sample,
  output logic [adnd_pkg::IDX_W-1:0]            step_index
);
  import adnd_pkg::*;

  localparam int AW = $clog2(STEP_ENTRIES);
  localparam int AdjAW = $clog2(ADJ_ENTRIES);
  // Highest legal step index: last table entry, never above 63.
  localparam logic [IDX_W-1:0] IDX_MAX =
    (STEP_ENTRIES > 64) ? {IDX_W{1'b1}} : IDX_W'(STEP_ENTRIES - 1);

  // Committed state; the result channel shows it directly.
  logic [IDX_W-1:0]    cur_index;
  logic [SAMPLE_W-1:0] predictor;

  // Decoder stage: the item whose table reads are in flight.
  logic   s1_valid;
  stage_t s1;

  logic accept;
  logic s1_go;

  logic [STEP_W-1:0]      step_rdata;
  logic [ADJ_W-1:0]       adj_rdata;
  logic [ADDR_W_MAX-1:0]  step_waddr_wide;
  logic [ADDR_W_MAX-1:0]  step_raddr_wide;
  logic                   step_we;
  logic                   adj_we;

  logic signed [IDX_W+1:0] idx_sum;
  logic [IDX_W-1:0]        idx_dec;
  logic [STEP_W+1:0]       mag_sum;
  logic [STEP_W-1:0]       mag;
  logic [SAMPLE_W-1:0]     pred_dec;
  logic [IDX_W-1:0]        idx_next;
  logic [SAMPLE_W-1:0]     pred_next;
  logic [IDX_W-1:0]        idx_front;

  // Hold the item side during reset and while the stage cannot drain.
  assign item_stall = rst | (s1_valid & result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;
  assign s1_go      = s1_valid & (~result_valid | ~result_stall);

  // Table writes at transfer, in item order; drop step writes past the table.
  assign step_we = accept && (mode == MODE_LOAD_STEP) && (int'(entry_addr) < STEP_ENTRIES);
  assign adj_we  = accept && (mode == MODE_LOAD_ADJ);
  assign step_waddr_wide = ADDR_W_MAX'(entry_addr);

  // Read the step at the index the stage ahead leaves behind.
  assign idx_front       = s1_valid ? idx_next : cur_index;
  assign step_raddr_wide = ADDR_W_MAX'(idx_front);

  adnd_ram #(
    .WIDTH (STEP_W),
    .DEPTH (STEP_ENTRIES)
  ) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr_wide[AW-1:0]),
    .wdata (entry_value),
    .re    (accept),
    .raddr (step_raddr_wide[AW-1:0]),
    .rdata (step_rdata)
  );

  adnd_ram #(
    .WIDTH (ADJ_W),
    .DEPTH (ADJ_ENTRIES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (code[AdjAW-1:0]),
    .wdata (adjust_value),
    .re    (accept),
    .raddr (code[AdjAW-1:0]),
    .rdata (adj_rdata)
  );

  // Index adaptation: add the signed adjustment, clamp to the table range.
  always_comb begin
    idx_sum = $signed({2'b00, cur_index}) + $signed({adj_rdata[ADJ_W-1], adj_rdata});
    if (idx_sum[IDX_W+1]) begin
      idx_dec = '0;
    end else if (idx_sum[IDX_W:0] > {1'b0, IDX_MAX}) begin
      idx_dec = IDX_MAX;
    end else begin
      idx_dec = idx_sum[IDX_W-1:0];
    end
  end

  // Delta magnitude from the step and code bits 2..0, wrapped to 16 bits.
  always_comb begin
    mag_sum = (STEP_W+2)'(step_rdata >> 3)
            + (s1.code[2] ? (STEP_W+2)'(step_rdata) : '0)
            + (s1.code[1] ? (STEP_W+2)'(step_rdata >> 1) : '0)
            + (s1.code[0] ? ((STEP_W+2)'(step_rdata >> 2) + (STEP_W+2)'(step_rdata[0]))
                          : '0);
    mag = mag_sum[STEP_W-1:0];
    if (s1.code[3]) begin
      pred_dec = predictor - SAMPLE_W'(mag);
    end else begin
      pred_dec = predictor + SAMPLE_W'(mag);
    end
  end

  // State after the staged item.
  always_comb begin
    unique case (s1.mode)
      MODE_DECODE: begin
        idx_next  = idx_dec;
        pred_next = pred_dec;
      end
      MODE_INIT: begin
        idx_next  = (s1.addr > IDX_MAX) ? IDX_MAX : s1.addr;
        pred_next = SAMPLE_W'(s1.value);
      end
      default: begin
        idx_next  = cur_index;
        pred_next = predictor;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      cur_index    <= '0;
      predictor    <= '0;
    end else begin
      // Advance the stage on a transfer, drop it once committed.
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      // Commit: state and result register are the same flops.
      if (s1_go) begin
        cur_index    <= idx_next;
        predictor    <= pred_next;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode  <= mode;
      s1.code  <= code;
      s1.addr  <= entry_addr;
      s1.value <= entry_value;
    end
  end

  assign sample     = $signed(predictor);
  assign step_index = cur_index;

endmodule

// ===== design/adnd_checker.sv =====
// Port-level assertions for the decoder core, bound to the top level.
module adnd_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  item_valid,
  input logic                                  item_stall,
  input adnd_pkg::mode_t                       mode,
  input logic [adnd_pkg::CODE_W-1:0]           code,
  input logic [adnd_pkg::IDX_W-1:0]            entry_addr,
  input logic [adnd_pkg::STEP_W-1:0]           entry_value,
  input logic signed [adnd_pkg::ADJ_W-1:0]     adjust_value,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic signed [adnd_pkg::SAMPLE_W-1:0]  sample,
  input logic [adnd_pkg::IDX_W-1:0]            step_index
);

  // A stalled item holds its valid and every field.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(mode) && $stable(code)
      && $stable(entry_addr) && $stable(entry_value) && $stable(adjust_value))
    else $error("item changed while stalled");

  // A stalled result holds its valid and its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(sample) && $stable(step_index))
    else $error("result changed while stalled");

  // Results never appear unless an item was taken ahead of them.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result without a transfer");

  // The item side only stalls when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stall without backpressure");

  // No result reported while the item side cannot have delivered one.
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind adaptive_delta_nibble_decoder_core adnd_checker u_adnd_checker (.*);
